>>> rtl/core/lav_pkg.sv
// Shared types and constants of the look-at view matrix pipeline.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package lav_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int UNIT_W      = FRAC_BITS + 2;      // unit axis component, signed
   localparam int QUOT_W      = FRAC_BITS + 1;      // normalize quotient magnitude
   localparam int NORM_W      = FRAC_BITS + 35;     // normalize input, signed
   localparam int NUM_W       = FRAC_BITS + 32;     // divider numerator
   localparam int AXY_W       = FRAC_BITS + 3;      // y axis component, signed
   localparam int UPZ_W       = UNIT_W + 32;        // up * z product
   localparam int PY_W        = 2 * UNIT_W;         // z * x product
   localparam int EY_W        = PY_W + 1;           // z cross x, full precision
   localparam int DP_W        = AXY_W + 32;         // axis * eye product
   localparam int DOT_W       = FRAC_BITS + 37;     // dot with eye
   localparam int RND_W       = DOT_W - FRAC_BITS + 1;
   localparam int GRP_BITS    = 8;
   localparam int GROUPS      = (NORM_W + GRP_BITS - 1) / GRP_BITS;
   localparam int TOP_W       = $clog2(NORM_W);
   localparam int SQRT_STAGES = 32;
   localparam int NORM_LAT    = SQRT_STAGES + QUOT_W + 8;
   localparam int GAP_CYCLES  = 4;
   localparam int GAP_W       = $clog2(GAP_CYCLES);

   localparam logic [31:0] ONE_Q   = 32'(1) << FRAC_BITS;
   localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

   typedef logic signed [NORM_W-1:0] nvec_type;
   typedef logic signed [UNIT_W-1:0] unit_type;

   typedef struct packed {
      logic signed [31:0] eye_x;
      logic signed [31:0] eye_y;
      logic signed [31:0] eye_z;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [31:0] target_z;
      logic signed [31:0] up_x;
      logic signed [31:0] up_y;
      logic signed [31:0] up_z;
   } req_type;

   typedef struct packed {
      logic [1:0]         row_index;
      logic signed [31:0] col0;
      logic signed [31:0] col1;
      logic signed [31:0] col2;
      logic signed [31:0] col3;
      logic               degenerate;
      logic               last_row;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] col0;
      logic signed [31:0] col1;
      logic signed [31:0] col2;
      logic signed [31:0] col3;
   } row_type;

   typedef struct packed {
      logic valid;
      logic degenerate;
   } mat_ctl_type;

endpackage

`default_nettype wire

>>> rtl/core/look_at_view_matrix.sv
// Look-at view matrix: an accepted transaction passes the input stage, z normalize,
// up cross z, x normalize, z cross x, the translation column and the row sequencer;
// rsp_strobe then carries row 0, and rows 1..3 follow on consecutive cycles. busy
// rises after each accept and holds off the next one so the row bursts never overlap.
// Synchronous reset clears all valid bits and the sequencer; no clearing pass.
`default_nettype none

module look_at_view_matrix
   import lav_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   logic             accept;
   logic [GAP_W-1:0] gap_ff;

   // input stage
   logic               t1_valid_ff;
   nvec_type           t1_d_ff   [3];
   logic signed [31:0] t1_eye_ff [3];
   logic signed [31:0] t1_up_ff  [3];

   // z normalize and its side data
   logic               z_valid, z_zero;
   unit_type           z_unit [3];
   logic signed [31:0] eyea_ff [NORM_LAT][3];
   logic signed [31:0] upa_ff  [NORM_LAT][3];

   // up cross z
   logic                   c1_valid_ff, c2_valid_ff;
   logic signed [UPZ_W-1:0] c1_p_ff [6];
   logic signed [31:0]     c1_eye_ff [3];
   logic signed [31:0]     c2_eye_ff [3];
   unit_type               c1_az_ff [3];
   unit_type               c2_az_ff [3];
   logic                   c1_dz_ff, c2_dz_ff;
   nvec_type               c2_raw_ff [3];

   // x normalize and its side data
   logic               x_valid, x_zero;
   unit_type           x_unit [3];
   logic signed [31:0] eyeb_ff [NORM_LAT][3];
   unit_type           azb_ff  [NORM_LAT][3];
   logic [NORM_LAT-1:0] dzb_ff;

   // z cross x
   logic [3:1]              y_valid_ff;
   logic signed [PY_W-1:0]  y1_p_ff [6];
   logic signed [EY_W-1:0]  y2_e_ff [3];
   logic signed [AXY_W-1:0] y3_y_ff [3];
   logic signed [31:0]      y_eye_ff [3:1][3];
   unit_type                y_ax_ff  [3:1][3];
   unit_type                y_az_ff  [3:1][3];
   logic [3:1]              y_dg_ff;
   logic [EY_W-1:0]         y_mag [3];
   logic [EY_W:0]           y_rnd [3];

   // translation column
   logic [4:1]              d_valid_ff;
   logic signed [AXY_W-1:0] axes [3][3];
   logic signed [AXY_W-1:0] d_axes_ff [4:1][3][3];
   logic [4:1]              d_dg_ff;
   logic signed [DP_W-1:0]  d1_p_ff [3][3];
   logic signed [DOT_W-1:0] d2_dot_ff [3];
   logic [RND_W-1:0]        d3_rnd_ff [3];
   logic [2:0]              d3_neg_ff;
   logic [DOT_W-1:0]        d_mag [3];
   logic [DOT_W:0]          d_sum [3];
   logic [31:0]             d4_col3_ff [3];

   mat_ctl_type mat_ctl;
   row_type     mat_row [3];

   assign accept = start && !busy;
   assign busy   = (gap_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= '0;
      end else if (accept) begin
         gap_ff <= GAP_W'(GAP_CYCLES - 1);
      end else if (gap_ff != '0) begin
         gap_ff <= gap_ff - GAP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff <= 1'b0;
         c1_valid_ff <= 1'b0;
         c2_valid_ff <= 1'b0;
         y_valid_ff  <= '0;
         d_valid_ff  <= '0;
      end else begin
         t1_valid_ff <= accept;
         c1_valid_ff <= z_valid;
         c2_valid_ff <= c1_valid_ff;
         y_valid_ff  <= {y_valid_ff[2:1], x_valid};
         d_valid_ff  <= {d_valid_ff[3:1], y_valid_ff[3]};
      end
   end

   always_ff @(posedge clock) begin
      t1_d_ff[0]   <= NORM_W'(req_data.eye_x) - NORM_W'(req_data.target_x);
      t1_d_ff[1]   <= NORM_W'(req_data.eye_y) - NORM_W'(req_data.target_y);
      t1_d_ff[2]   <= NORM_W'(req_data.eye_z) - NORM_W'(req_data.target_z);
      t1_eye_ff[0] <= req_data.eye_x;
      t1_eye_ff[1] <= req_data.eye_y;
      t1_eye_ff[2] <= req_data.eye_z;
      t1_up_ff[0]  <= req_data.up_x;
      t1_up_ff[1]  <= req_data.up_y;
      t1_up_ff[2]  <= req_data.up_z;
   end

   lav_norm u_norm_z (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (t1_valid_ff),
      .in_vec    (t1_d_ff),
      .out_valid (z_valid),
      .out_zero  (z_zero),
      .out_unit  (z_unit)
   );

   always_ff @(posedge clock) begin
      eyea_ff[0] <= t1_eye_ff;
      upa_ff[0]  <= t1_up_ff;
      for (int k = 1; k < NORM_LAT; k++) begin
         eyea_ff[k] <= eyea_ff[k-1];
         upa_ff[k]  <= upa_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      c1_p_ff[0] <= upa_ff[NORM_LAT-1][1] * z_unit[2];
      c1_p_ff[1] <= upa_ff[NORM_LAT-1][2] * z_unit[1];
      c1_p_ff[2] <= upa_ff[NORM_LAT-1][2] * z_unit[0];
      c1_p_ff[3] <= upa_ff[NORM_LAT-1][0] * z_unit[2];
      c1_p_ff[4] <= upa_ff[NORM_LAT-1][0] * z_unit[1];
      c1_p_ff[5] <= upa_ff[NORM_LAT-1][1] * z_unit[0];
      c1_eye_ff  <= eyea_ff[NORM_LAT-1];
      c1_az_ff   <= z_unit;
      c1_dz_ff   <= z_zero;

      for (int i = 0; i < 3; i++) begin
         c2_raw_ff[i] <= NORM_W'(c1_p_ff[2*i]) - NORM_W'(c1_p_ff[2*i+1]);
      end
      c2_eye_ff <= c1_eye_ff;
      c2_az_ff  <= c1_az_ff;
      c2_dz_ff  <= c1_dz_ff;
   end

   lav_norm u_norm_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c2_valid_ff),
      .in_vec    (c2_raw_ff),
      .out_valid (x_valid),
      .out_zero  (x_zero),
      .out_unit  (x_unit)
   );

   always_ff @(posedge clock) begin
      eyeb_ff[0] <= c2_eye_ff;
      azb_ff[0]  <= c2_az_ff;
      for (int k = 1; k < NORM_LAT; k++) begin
         eyeb_ff[k] <= eyeb_ff[k-1];
         azb_ff[k]  <= azb_ff[k-1];
      end
      dzb_ff <= {dzb_ff[NORM_LAT-2:0], c2_dz_ff};
   end

   // y = z cross x, rounded half away from zero
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         y_mag[i] = y2_e_ff[i][EY_W-1] ? EY_W'(-y2_e_ff[i]) : EY_W'(y2_e_ff[i]);
         y_rnd[i] = (EY_W+1)'(y_mag[i]) + ((EY_W+1)'(1) << (FRAC_BITS - 1));
      end
   end

   always_ff @(posedge clock) begin
      y1_p_ff[0] <= azb_ff[NORM_LAT-1][1] * x_unit[2];
      y1_p_ff[1] <= azb_ff[NORM_LAT-1][2] * x_unit[1];
      y1_p_ff[2] <= azb_ff[NORM_LAT-1][2] * x_unit[0];
      y1_p_ff[3] <= azb_ff[NORM_LAT-1][0] * x_unit[2];
      y1_p_ff[4] <= azb_ff[NORM_LAT-1][0] * x_unit[1];
      y1_p_ff[5] <= azb_ff[NORM_LAT-1][1] * x_unit[0];
      y_eye_ff[1] <= eyeb_ff[NORM_LAT-1];
      y_az_ff[1]  <= azb_ff[NORM_LAT-1];
      y_ax_ff[1]  <= x_unit;
      y_dg_ff[1]  <= dzb_ff[NORM_LAT-1] | x_zero;

      for (int i = 0; i < 3; i++) begin
         y2_e_ff[i] <= EY_W'(y1_p_ff[2*i]) - EY_W'(y1_p_ff[2*i+1]);
      end
      for (int i = 0; i < 3; i++) begin
         if (y2_e_ff[i][EY_W-1]) begin
            y3_y_ff[i] <= -AXY_W'(y_rnd[i] >> FRAC_BITS);
         end else begin
            y3_y_ff[i] <= AXY_W'(y_rnd[i] >> FRAC_BITS);
         end
      end
      for (int k = 2; k <= 3; k++) begin
         y_eye_ff[k] <= y_eye_ff[k-1];
         y_az_ff[k]  <= y_az_ff[k-1];
         y_ax_ff[k]  <= y_ax_ff[k-1];
         y_dg_ff[k]  <= y_dg_ff[k-1];
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         axes[0][j] = AXY_W'(y_ax_ff[3][j]);
         axes[1][j] = y3_y_ff[j];
         axes[2][j] = AXY_W'(y_az_ff[3][j]);
      end
   end

   // translation: -(axis dot eye), rounded half away from zero, saturated
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         d_mag[r] = d2_dot_ff[r][DOT_W-1] ? DOT_W'(-d2_dot_ff[r]) : DOT_W'(d2_dot_ff[r]);
         d_sum[r] = (DOT_W+1)'(d_mag[r]) + ((DOT_W+1)'(1) << (FRAC_BITS - 1));
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         for (int j = 0; j < 3; j++) begin
            d1_p_ff[r][j] <= axes[r][j] * y_eye_ff[3][j];
         end
      end
      d_axes_ff[1] <= axes;
      d_dg_ff[1]   <= y_dg_ff[3];

      for (int r = 0; r < 3; r++) begin
         d2_dot_ff[r] <= DOT_W'(d1_p_ff[r][0]) + DOT_W'(d1_p_ff[r][1])
                         + DOT_W'(d1_p_ff[r][2]);
      end

      for (int r = 0; r < 3; r++) begin
         d3_rnd_ff[r] <= RND_W'(d_sum[r] >> FRAC_BITS);
         d3_neg_ff[r] <= d2_dot_ff[r][DOT_W-1];
      end

      for (int r = 0; r < 3; r++) begin
         if (d3_neg_ff[r]) begin
            d4_col3_ff[r] <= (d3_rnd_ff[r] > RND_W'(SAT_MAX)) ? SAT_MAX
                             : d3_rnd_ff[r][31:0];
         end else begin
            d4_col3_ff[r] <= (d3_rnd_ff[r] > RND_W'(SAT_MIN)) ? SAT_MIN
                             : -d3_rnd_ff[r][31:0];
         end
      end

      for (int k = 2; k <= 4; k++) begin
         d_axes_ff[k] <= d_axes_ff[k-1];
         d_dg_ff[k]   <= d_dg_ff[k-1];
      end
   end

   always_comb begin
      mat_ctl.valid      = d_valid_ff[4];
      mat_ctl.degenerate = d_dg_ff[4];
      for (int r = 0; r < 3; r++) begin
         mat_row[r].col0 = 32'(d_axes_ff[4][r][0]);
         mat_row[r].col1 = 32'(d_axes_ff[4][r][1]);
         mat_row[r].col2 = 32'(d_axes_ff[4][r][2]);
         mat_row[r].col3 = d4_col3_ff[r];
      end
   end

   lav_rows u_rows (
      .clock      (clock),
      .reset      (reset),
      .mat_ctl    (mat_ctl),
      .mat_row    (mat_row),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // accept holds off the next transaction for the rest of the row burst
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after accept");

   // rows of one matrix come on back-to-back cycles
   a_rows_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_row |=> rsp_strobe)
      else $error("row burst broken");

   a_row_order: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_row |=>
         rsp_data.row_index == 2'($past(rsp_data.row_index) + 2'd1))
      else $error("row index out of order");

   a_last_row: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.last_row == (rsp_data.row_index == 2'd3)))
      else $error("last_row mismatch");

   a_matrix_idle: assert property (@(posedge clock) disable iff (reset)
      mat_ctl.valid |-> !rsp_strobe || rsp_data.last_row)
      else $error("new matrix while rows pending");

endmodule

`default_nettype wire

>>> rtl/core/lav_isqrt.sv
// Pipelined integer square root, two radicand bits per stage.
// Depends on lav_pkg.
`default_nettype none

module lav_isqrt
   import lav_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [63:0] in_value,
   output logic        out_valid,
   output logic [31:0] out_root
);

   logic [SQRT_STAGES-1:0] valid_ff;
   logic [63:0] rad_ff  [SQRT_STAGES];
   logic [63:0] rad_in  [SQRT_STAGES];
   logic [34:0] rem_ff  [SQRT_STAGES];
   logic [34:0] rem_in  [SQRT_STAGES];
   logic [31:0] root_ff [SQRT_STAGES];
   logic [31:0] root_in [SQRT_STAGES];

   logic [63:0] src_rad  [SQRT_STAGES];
   logic [34:0] src_rem  [SQRT_STAGES];
   logic [31:0] src_root [SQRT_STAGES];
   logic [34:0] part     [SQRT_STAGES];
   logic [34:0] trial    [SQRT_STAGES];

   always_comb begin
      for (int s = 0; s < SQRT_STAGES; s++) begin
         if (s == 0) begin
            src_rad[s]  = in_value;
            src_rem[s]  = '0;
            src_root[s] = '0;
         end else begin
            src_rad[s]  = rad_ff[s-1];
            src_rem[s]  = rem_ff[s-1];
            src_root[s] = root_ff[s-1];
         end
         part[s]   = {src_rem[s][32:0], src_rad[s][63:62]};
         trial[s]  = {1'b0, src_root[s], 2'b01};
         rad_in[s] = {src_rad[s][61:0], 2'b00};
         if (part[s] >= trial[s]) begin
            rem_in[s]  = part[s] - trial[s];
            root_in[s] = {src_root[s][30:0], 1'b1};
         end else begin
            rem_in[s]  = part[s];
            root_in[s] = {src_root[s][30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[SQRT_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign out_valid = valid_ff[SQRT_STAGES-1];
   assign out_root  = root_ff[SQRT_STAGES-1];

endmodule

`default_nettype wire

>>> rtl/core/lav_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on lav_pkg.
`default_nettype none

module lav_div
   import lav_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [31:0]       in_den,
   output logic              out_valid,
   output logic [QUOT_W-1:0] out_quot
);

   logic [QUOT_W-1:0] valid_ff;
   logic [NUM_W-1:0]  rem_ff  [QUOT_W];
   logic [NUM_W-1:0]  rem_in  [QUOT_W];
   logic [31:0]       den_ff  [QUOT_W];
   logic [31:0]       den_in  [QUOT_W];
   logic [QUOT_W-1:0] quot_ff [QUOT_W];
   logic [QUOT_W-1:0] quot_in [QUOT_W];

   logic [NUM_W-1:0]  src_rem  [QUOT_W];
   logic [QUOT_W-1:0] src_quot [QUOT_W];
   logic [NUM_W-1:0]  shifted  [QUOT_W];

   // stage s decides quotient bit QUOT_W-1-s
   always_comb begin
      for (int s = 0; s < QUOT_W; s++) begin
         if (s == 0) begin
            src_rem[s]  = in_num;
            den_in[s]   = in_den;
            src_quot[s] = '0;
         end else begin
            src_rem[s]  = rem_ff[s-1];
            den_in[s]   = den_ff[s-1];
            src_quot[s] = quot_ff[s-1];
         end
         shifted[s] = NUM_W'(den_in[s]) << (QUOT_W - 1 - s);
         if (src_rem[s] >= shifted[s]) begin
            rem_in[s]  = src_rem[s] - shifted[s];
            quot_in[s] = src_quot[s] | (QUOT_W'(1) << (QUOT_W - 1 - s));
         end else begin
            rem_in[s]  = src_rem[s];
            quot_in[s] = src_quot[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[QUOT_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign out_valid = valid_ff[QUOT_W-1];
   assign out_quot  = quot_ff[QUOT_W-1];

endmodule

`default_nettype wire

>>> rtl/core/lav_norm.sv
// Vector normalize pipeline: scale to top bit 30, length by square root,
// per-component rounded divide. Depends on lav_pkg, lav_isqrt, lav_div.
`default_nettype none

module lav_norm
   import lav_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  nvec_type in_vec [3],
   output logic     out_valid,
   output logic     out_zero,
   output unit_type out_unit [3]
);

   // magnitudes
   logic [NORM_W-1:0] mag1_ff [3];
   logic [NORM_W-1:0] mag1_in [3];
   logic [2:0]        neg1_ff;
   logic [NORM_W-1:0] or1_ff;
   // per-group leading one
   logic [NORM_W-1:0]       mag2_ff [3];
   logic [2:0]              neg2_ff;
   logic [GROUPS-1:0]       nz2_ff, nz2_in;
   logic [2:0]              idx2_ff [GROUPS];
   logic [2:0]              idx2_in [GROUPS];
   logic [GROUPS*GRP_BITS-1:0] padded;
   // top bit
   logic [NORM_W-1:0] mag3_ff [3];
   logic [2:0]        neg3_ff;
   logic [TOP_W-1:0]  top3_ff, top3_in;
   logic              zero3_ff, zero3_in;
   // scaled
   logic [NORM_W-1:0] shift_tmp [3];
   logic [30:0]       sm4_ff [3];
   logic [30:0]       sm4_in [3];
   logic [2:0]        neg4_ff;
   logic              zero4_ff;
   // squares and sum
   logic [30:0] sm5_ff [3];
   logic [61:0] sq5_ff [3];
   logic [2:0]  neg5_ff;
   logic        zero5_ff;
   logic [30:0] sm6_ff [3];
   logic [63:0] sum6_ff;
   logic [2:0]  neg6_ff;
   logic        zero6_ff;
   logic [6:1]  valid_ff;
   // across the square root
   logic [30:0]            smd_ff  [SQRT_STAGES][3];
   logic [2:0]             negd_ff [SQRT_STAGES];
   logic [SQRT_STAGES-1:0] zerod_ff;
   logic                   root_valid;
   logic [31:0]            root;
   // numerators
   logic [NUM_W-1:0] num7_ff [3];
   logic [31:0]      den7_ff;
   logic [2:0]       neg7_ff;
   logic             zero7_ff;
   logic             valid7_ff;
   // across the divide
   logic [2:0]        div_valid;
   logic [QUOT_W-1:0] quot [3];
   logic [2:0]        negq_ff [QUOT_W];
   logic [QUOT_W-1:0] zeroq_ff;
   // output
   unit_type out_ff [3];
   logic     out_zero_ff, out_valid_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag1_in[i] = in_vec[i][NORM_W-1] ? NORM_W'(-in_vec[i]) : NORM_W'(in_vec[i]);
      end
   end

   always_comb begin
      padded = (GROUPS*GRP_BITS)'(or1_ff);
      for (int g = 0; g < GROUPS; g++) begin
         nz2_in[g]  = |padded[g*GRP_BITS +: GRP_BITS];
         idx2_in[g] = '0;
         for (int b = 0; b < GRP_BITS; b++) begin
            if (padded[g*GRP_BITS + b]) idx2_in[g] = 3'(b);
         end
      end
   end

   always_comb begin
      top3_in  = '0;
      zero3_in = 1'b1;
      for (int g = 0; g < GROUPS; g++) begin
         if (nz2_ff[g]) begin
            top3_in  = TOP_W'(g * GRP_BITS) + TOP_W'(idx2_ff[g]);
            zero3_in = 1'b0;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (top3_ff > TOP_W'(30)) begin
            shift_tmp[i] = mag3_ff[i] >> (top3_ff - TOP_W'(30));
         end else begin
            shift_tmp[i] = mag3_ff[i] << (TOP_W'(30) - top3_ff);
         end
         sm4_in[i] = shift_tmp[i][30:0];
      end
   end

   lav_isqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_ff[6]),
      .in_value  (sum6_ff),
      .out_valid (root_valid),
      .out_root  (root)
   );

   for (genvar i = 0; i < 3; i++) begin : g_div
      lav_div u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid7_ff),
         .in_num    (num7_ff[i]),
         .in_den    (den7_ff),
         .out_valid (div_valid[i]),
         .out_quot  (quot[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         valid7_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= {valid_ff[5:1], in_valid};
         valid7_ff    <= root_valid;
         out_valid_ff <= &div_valid;
      end
   end

   always_ff @(posedge clock) begin
      mag1_ff <= mag1_in;
      for (int i = 0; i < 3; i++) neg1_ff[i] <= in_vec[i][NORM_W-1];
      or1_ff  <= mag1_in[0] | mag1_in[1] | mag1_in[2];

      mag2_ff <= mag1_ff;
      neg2_ff <= neg1_ff;
      nz2_ff  <= nz2_in;
      idx2_ff <= idx2_in;

      mag3_ff  <= mag2_ff;
      neg3_ff  <= neg2_ff;
      top3_ff  <= top3_in;
      zero3_ff <= zero3_in;

      sm4_ff   <= sm4_in;
      neg4_ff  <= neg3_ff;
      zero4_ff <= zero3_ff;

      sm5_ff <= sm4_ff;
      for (int i = 0; i < 3; i++) sq5_ff[i] <= sm4_ff[i] * sm4_ff[i];
      neg5_ff  <= neg4_ff;
      zero5_ff <= zero4_ff;

      sm6_ff   <= sm5_ff;
      sum6_ff  <= 64'(sq5_ff[0]) + 64'(sq5_ff[1]) + 64'(sq5_ff[2]);
      neg6_ff  <= neg5_ff;
      zero6_ff <= zero5_ff;

      smd_ff[0]  <= sm6_ff;
      negd_ff[0] <= neg6_ff;
      for (int k = 1; k < SQRT_STAGES; k++) begin
         smd_ff[k]  <= smd_ff[k-1];
         negd_ff[k] <= negd_ff[k-1];
      end
      zerod_ff <= {zerod_ff[SQRT_STAGES-2:0], zero6_ff};

      // rounded half up: (m << F) + len/2
      for (int i = 0; i < 3; i++) begin
         num7_ff[i] <= (NUM_W'(smd_ff[SQRT_STAGES-1][i]) << FRAC_BITS)
                       + NUM_W'(root >> 1);
      end
      den7_ff  <= root;
      neg7_ff  <= negd_ff[SQRT_STAGES-1];
      zero7_ff <= zerod_ff[SQRT_STAGES-1];

      negq_ff[0] <= neg7_ff;
      for (int k = 1; k < QUOT_W; k++) negq_ff[k] <= negq_ff[k-1];
      zeroq_ff <= {zeroq_ff[QUOT_W-2:0], zero7_ff};

      for (int i = 0; i < 3; i++) begin
         if (zeroq_ff[QUOT_W-1]) begin
            out_ff[i] <= '0;
         end else if (negq_ff[QUOT_W-1][i]) begin
            out_ff[i] <= -UNIT_W'(quot[i]);
         end else begin
            out_ff[i] <= UNIT_W'(quot[i]);
         end
      end
      out_zero_ff <= zeroq_ff[QUOT_W-1];
   end

   assign out_valid = out_valid_ff;
   assign out_zero  = out_zero_ff;
   assign out_unit  = out_ff;

endmodule

`default_nettype wire

>>> rtl/core/lav_rows.sv
// Row sequencer: holds a finished matrix and drives one row per cycle.
// Depends on lav_pkg.
`default_nettype none

module lav_rows
   import lav_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mat_ctl_type mat_ctl,
   input  row_type     mat_row [3],
   output logic        rsp_strobe,
   output rsp_type     rsp_data
);

   row_type    hold_ff [3];
   logic       degen_ff;
   logic [1:0] cnt_ff;
   logic       run_ff;
   logic       strobe_ff;
   rsp_type    rsp_ff, rsp_in;
   row_type    cur;

   always_comb begin
      if (mat_ctl.valid) begin
         cur = mat_row[0];
      end else if (cnt_ff == 2'd3) begin
         cur = '{col0: '0, col1: '0, col2: '0, col3: ONE_Q};
      end else begin
         cur = hold_ff[cnt_ff];
      end
      rsp_in.row_index  = mat_ctl.valid ? 2'd0 : cnt_ff;
      rsp_in.col0       = cur.col0;
      rsp_in.col1       = cur.col1;
      rsp_in.col2       = cur.col2;
      rsp_in.col3       = cur.col3;
      rsp_in.degenerate = mat_ctl.valid ? mat_ctl.degenerate : degen_ff;
      rsp_in.last_row   = !mat_ctl.valid && (cnt_ff == 2'd3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else if (mat_ctl.valid) begin
         run_ff    <= 1'b1;
         cnt_ff    <= 2'd1;
         strobe_ff <= 1'b1;
      end else if (run_ff) begin
         run_ff    <= (cnt_ff != 2'd3);
         cnt_ff    <= cnt_ff + 2'd1;
         strobe_ff <= 1'b1;
      end else begin
         strobe_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mat_ctl.valid) begin
         hold_ff  <= mat_row;
         degen_ff <= mat_ctl.degenerate;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

>>> bench/tb_look_at_view_matrix.sv
// Testbench for look_at_view_matrix: directed table plus random transactions,
// each checked row by row against a fixed-point predictor. Depends on lav_pkg.
`default_nettype none

module tb_look_at_view_matrix;
   import lav_pkg::*;

   localparam int LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   rsp_type rows_due[$];
   int      n_err = 0;
   int      cycle = 0;
   int      idle_pct = 0;

   typedef struct {
      req_type req;
      logic    check_fixed;
      rsp_type row0;
      rsp_type row3;
   } vec_type;

   always #1 clock = ~clock;

   look_at_view_matrix u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   function automatic logic [63:0] mag(input longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint round_frac(input longint v);
      logic [63:0] m;
      m = (mag(v) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return v < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return SAT_MAX;
      if (v < -64'sd2147483648) return SAT_MIN;
      return v[31:0];
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else res >>= 1;
         bitv >>= 2;
      end
      return res;
   endfunction

   // returns 1 when the vector has zero length
   function automatic logic unit_vec(input longint v[3], output longint u[3]);
      logic [63:0] m[3], mx, sum, len, q;
      int top;
      mx = 0;
      sum = 0;
      top = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = mag(v[i]);
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
         u = '{0, 0, 0};
         return 1'b1;
      end
      while (top < 63 && (mx >> (top + 1)) != 0) top++;
      for (int i = 0; i < 3; i++) begin
         if (top > 30) m[i] >>= (top - 30);
         else m[i] <<= (30 - top);
         sum += m[i] * m[i];
      end
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
         u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1'b0;
   endfunction

   task automatic predict_view_rows(input req_type r);
      longint eye[3], d[3], up[3], raw[3], ax[3][3], dot;
      logic degen;
      rsp_type row;
      eye = '{r.eye_x, r.eye_y, r.eye_z};
      up = '{r.up_x, r.up_y, r.up_z};
      d = '{eye[0] - r.target_x, eye[1] - r.target_y, eye[2] - r.target_z};
      degen = unit_vec(d, ax[2]);
      raw[0] = up[1] * ax[2][2] - up[2] * ax[2][1];
      raw[1] = up[2] * ax[2][0] - up[0] * ax[2][2];
      raw[2] = up[0] * ax[2][1] - up[1] * ax[2][0];
      if (unit_vec(raw, ax[0])) degen = 1'b1;
      ax[1][0] = round_frac(ax[2][1] * ax[0][2] - ax[2][2] * ax[0][1]);
      ax[1][1] = round_frac(ax[2][2] * ax[0][0] - ax[2][0] * ax[0][2]);
      ax[1][2] = round_frac(ax[2][0] * ax[0][1] - ax[2][1] * ax[0][0]);
      for (int k = 0; k < 4; k++) begin
         row = '0;
         row.row_index = k[1:0];
         row.degenerate = degen;
         row.last_row = (k == 3);
         if (k < 3) begin
            dot = ax[k][0] * eye[0] + ax[k][1] * eye[1] + ax[k][2] * eye[2];
            row.col0 = clamp32(ax[k][0]);
            row.col1 = clamp32(ax[k][1]);
            row.col2 = clamp32(ax[k][2]);
            row.col3 = clamp32(-round_frac(dot));
         end else row.col3 = ONE_Q;
         rows_due.push_back(row);
      end
   endtask

   task automatic report(input string what, input rsp_type got, input rsp_type want);
      $display("mismatch %s: got %h want %h", what, got, want);
      n_err++;
   endtask

   function automatic req_type rand_req();
      req_type r;
      int mode;
      mode = $urandom_range(0, 9);
      r = {$urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom};
      if (mode < 4) begin
         // modest scene coordinates
         r.eye_x = $signed($urandom_range(0, 2 << 22)) - (1 << 22);
         r.eye_y = $signed($urandom_range(0, 2 << 22)) - (1 << 22);
         r.eye_z = $signed($urandom_range(0, 2 << 22)) - (1 << 22);
         r.target_x = $signed($urandom_range(0, 2 << 22)) - (1 << 22);
         r.target_y = $signed($urandom_range(0, 2 << 22)) - (1 << 22);
         r.target_z = $signed($urandom_range(0, 2 << 22)) - (1 << 22);
         r.up_x = $signed($urandom_range(0, 2 << 17)) - (1 << 17);
         r.up_y = $signed($urandom_range(0, 2 << 17)) - (1 << 17);
         r.up_z = $signed($urandom_range(0, 2 << 17)) - (1 << 17);
      end else if (mode == 4) begin
         r.target_x = r.eye_x; r.target_y = r.eye_y; r.target_z = r.eye_z;
      end else if (mode == 5) begin
         // up along the view direction
         r.target_x = r.eye_x - 32'sd65536;
         r.target_y = r.eye_y; r.target_z = r.eye_z;
         r.up_y = 0; r.up_z = 0;
      end else if (mode == 6) begin
         r.up_x = 0; r.up_y = 0; r.up_z = 0;
      end
      return r;
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      cycle <= cycle + 1;
      if (!reset && rsp_strobe) begin
         if (rows_due.size() == 0) begin
            report("unexpected", rsp_data, '0);
         end else begin
            want = rows_due.pop_front();
            if (rsp_data.row_index !== want.row_index) report("row_index", rsp_data, want);
            if (rsp_data.col0 !== want.col0) report("col0", rsp_data, want);
            if (rsp_data.col1 !== want.col1) report("col1", rsp_data, want);
            if (rsp_data.col2 !== want.col2) report("col2", rsp_data, want);
            if (rsp_data.col3 !== want.col3) report("col3", rsp_data, want);
            if (rsp_data.degenerate !== want.degenerate) report("degenerate", rsp_data, want);
            if (rsp_data.last_row !== want.last_row) report("last_row", rsp_data, want);
         end
      end
      if (cycle > LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // holds req for one transaction, with random idle cycles before it;
   // start stays high on return so back-to-back sends need no gap
   task automatic send(input req_type r);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_view_rows(r);
   endtask

   initial begin
      vec_type dir[$];
      vec_type v;
      rsp_type r0, r3;
      int phase_pct[4];
      phase_pct = '{0, 63, 0, 8};

      // eye == target: everything zero but the last row
      v.req = '0;
      v.req.eye_x = 32'sd65536; v.req.target_x = 32'sd65536;
      v.req.up_y = 32'sd65536;
      v.check_fixed = 1'b1;
      r0 = '0; r0.degenerate = 1'b1;
      r3 = '0; r3.row_index = 2'd3; r3.col3 = ONE_Q; r3.degenerate = 1'b1; r3.last_row = 1'b1;
      v.row0 = r0; v.row3 = r3;
      dir.push_back(v);
      // canonical camera at origin looking down -z, up +y: x axis = (1,0,0)
      v.req = '0; v.req.target_z = -32'sd65536; v.req.up_y = 32'sd65536;
      r0 = '0; r0.col0 = ONE_Q;
      r3.degenerate = 1'b0;
      v.row0 = r0; v.row3 = r3;
      dir.push_back(v);
      v.check_fixed = 1'b0;
      // up zero, up parallel, extremes
      v.req = '0; v.req.target_z = -32'sd65536; dir.push_back(v);
      v.req = '0; v.req.target_y = 32'sd65536; v.req.up_y = 32'sd65536; dir.push_back(v);
      v.req = {9{32'h7fff_ffff}}; v.req.target_x = 32'h8000_0000; dir.push_back(v);
      v.req = {9{32'h8000_0000}}; v.req.target_y = 32'h7fff_ffff; dir.push_back(v);
      v.req = {32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
      dir.push_back(v);
      v.req = {9{32'hffff_ffff}}; v.req.eye_z = 0; dir.push_back(v);
      v.req = {9{32'h0000_0001}}; v.req.target_x = 0; dir.push_back(v);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir[i]) begin
         send(dir[i].req);
         // the last four queued rows belong to this transaction
         if (dir[i].check_fixed) begin
            if (rows_due[rows_due.size() - 4] !== dir[i].row0)
               report("table row 0", rows_due[rows_due.size() - 4], dir[i].row0);
            if (rows_due[rows_due.size() - 1] !== dir[i].row3)
               report("table row 3", rows_due[rows_due.size() - 1], dir[i].row3);
         end
      end
      for (int p = 0; p < 4; p++) begin
         idle_pct = phase_pct[p];
         for (int i = 0; i < 38; i++) send(rand_req());
         // after phase 1, drain before the next phase
         if (p == 1) begin
            start <= 1'b0;
            while (rows_due.size() != 0) @(posedge clock);
         end
      end
      start <= 1'b0;
      while (rows_due.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (n_err == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire
